/* src/sfq_pkg.sv */
// Shared types, codes and defaults for the searchable FIFO queue.
`timescale 1ns / 1ps
`default_nettype none

package sfq_pkg;

   // Default number of entries the queue can hold.
   localparam int DefaultDepth = 16;

   // Field widths of the request and response words.
   localparam int OpWidth     = 3;
   localparam int ValueWidth  = 32;
   localparam int PosWidth    = 5;
   localparam int StatusWidth = 3;

   // Operation codes.
   localparam logic [OpWidth-1:0] OP_PUSH   = 3'd0;
   localparam logic [OpWidth-1:0] OP_POP    = 3'd1;
   localparam logic [OpWidth-1:0] OP_PEEK   = 3'd2;
   localparam logic [OpWidth-1:0] OP_SEARCH = 3'd3;
   localparam logic [OpWidth-1:0] OP_MAX    = 3'd4;
   localparam logic [OpWidth-1:0] OP_REMOVE = 3'd5;

   // Status codes.
   localparam logic [StatusWidth-1:0] ST_OK       = 3'd0;
   localparam logic [StatusWidth-1:0] ST_EMPTY    = 3'd1;
   localparam logic [StatusWidth-1:0] ST_FULL     = 3'd2;
   localparam logic [StatusWidth-1:0] ST_RANGE    = 3'd3;
   localparam logic [StatusWidth-1:0] ST_NOTFOUND = 3'd4;

   // Request word.
   typedef struct packed {
      logic [OpWidth-1:0]           operation;
      logic signed [ValueWidth-1:0] value;
      logic [PosWidth-1:0]          position;
   } req_type;

   // Response word.
   typedef struct packed {
      logic signed [ValueWidth-1:0] data;
      logic [PosWidth-1:0]          found_position;
      logic [StatusWidth-1:0]       status;
      logic [PosWidth-1:0]          length;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic finish_check;
      logic walk_init;
      logic walk_step;
      logic finish_walk;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pre_stop;
      logic walk_last;
   } stat_type;

endpackage

`default_nettype wire

/* src/sfq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sfq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire                                      clock,
   input  wire                                      wr_en,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire [WIDTH-1:0]                          wr_data,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/sfq_ctrl.sv */
// Controller state machine that sequences each queue operation.
`timescale 1ns / 1ps
`default_nettype none

module sfq_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   input  wire sfq_pkg::stat_type  stat,
   output sfq_pkg::cmd_type        cmd,
   output logic                    busy,
   output logic                    rsp_valid
);
   import sfq_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_WALK  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.pre_stop) begin
               cmd.finish_check = 1'b1;
               state_in         = S_IDLE;
            end else begin
               cmd.walk_init = 1'b1;
               state_in      = S_WALK;
            end
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.walk_last) begin
               cmd.finish_walk = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign valid_in = cmd.finish_check | cmd.finish_walk;

   // State and response strobe registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

/* src/sfq_datapath.sv */
// Datapath of the queue: pointers, entry store, walk counters and result register.
`timescale 1ns / 1ps
`default_nettype none

module sfq_datapath #(
   parameter int DEPTH = sfq_pkg::DefaultDepth
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire sfq_pkg::req_type   req_payload,
   input  wire sfq_pkg::cmd_type   cmd,
   output sfq_pkg::stat_type       stat,
   output sfq_pkg::rsp_type        rsp_payload
);
   import sfq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > PosWidth) ? CW : PosWidth;

   // Captured request.
   logic [OpWidth-1:0]           op_ff;
   logic signed [ValueWidth-1:0] val_ff;
   logic [PosWidth-1:0]          pos_ff;

   // Queue pointers.
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;

   // Walk counters.
   logic [CW-1:0] scan_ff, lag_ff, start_ff, end_ff;
   logic          lag_valid_ff;

   // Running result of the walk.
   logic signed [ValueWidth-1:0] acc_ff, acc_in;

   // Response register.
   rsp_type rsp_ff;

   // Memory ports.
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [ValueWidth-1:0] wr_data;
   logic [AW-1:0]         rd_addr;
   logic [ValueWidth-1:0] rd_raw;
   logic signed [ValueWidth-1:0] rd_data;

   // Precheck results.
   logic [StatusWidth-1:0] pre_status;
   logic                   pre_stop;
   logic [CW-1:0]          start_off, end_off;
   logic [XW-1:0]          count_x, pos_x;
   logic [PosWidth-1:0]    pos_less;

   // Walk results.
   logic is_first, hit, push_ok;

   // Store slot of an offset from the head, wrapped once.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW + 1)'(head) + (CW + 1)'(off);
      if (sum >= (CW + 1)'(DEPTH)) begin
         sum = sum - (CW + 1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign count_x  = XW'(count_ff);
   assign pos_x    = XW'(pos_ff);
   assign pos_less = pos_ff - PosWidth'(1);

   // Error checks and walk bounds for the captured request.
   always_comb begin
      pre_status = ST_OK;
      pre_stop   = 1'b0;
      start_off  = '0;
      end_off    = '0;
      case (op_ff)
         OP_PUSH: begin
            pre_stop = 1'b1;
            if (count_ff == CW'(DEPTH)) begin
               pre_status = ST_FULL;
            end
         end
         OP_POP: begin
            if (count_ff == '0) begin
               pre_stop   = 1'b1;
               pre_status = ST_EMPTY;
            end
         end
         OP_PEEK: begin
            if (pos_x >= count_x) begin
               pre_stop   = 1'b1;
               pre_status = ST_RANGE;
            end else begin
               start_off = CW'(pos_ff);
               end_off   = CW'(pos_ff);
            end
         end
         OP_SEARCH: begin
            if (count_ff == '0) begin
               pre_stop   = 1'b1;
               pre_status = ST_NOTFOUND;
            end else begin
               end_off = count_ff - CW'(1);
            end
         end
         OP_MAX: begin
            if (count_ff == '0) begin
               pre_stop   = 1'b1;
               pre_status = ST_EMPTY;
            end else begin
               end_off = count_ff - CW'(1);
            end
         end
         OP_REMOVE: begin
            if (count_ff == '0) begin
               pre_stop   = 1'b1;
               pre_status = ST_EMPTY;
            end else if (pos_x == '0 || pos_x > count_x) begin
               pre_stop   = 1'b1;
               pre_status = ST_RANGE;
            end else begin
               start_off = CW'(pos_less);
               end_off   = count_ff - CW'(1);
            end
         end
         default: begin
            pre_stop   = 1'b1;
            pre_status = ST_RANGE;
         end
      endcase
   end

   assign push_ok = (op_ff == OP_PUSH) && (pre_status == ST_OK);

   // Element handling during the walk; the read data belongs to lag_ff.
   assign rd_data  = $signed(rd_raw);
   assign is_first = (lag_ff == start_ff);
   assign hit      = lag_valid_ff && (op_ff == OP_SEARCH) && (rd_data == val_ff);

   always_comb begin
      acc_in = acc_ff;
      if (lag_valid_ff) begin
         case (op_ff)
            OP_POP, OP_PEEK: begin
               acc_in = rd_data;
            end
            OP_MAX: begin
               if (is_first || (rd_data > acc_ff)) begin
                  acc_in = rd_data;
               end
            end
            OP_REMOVE: begin
               if (is_first) begin
                  acc_in = rd_data;
               end
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   assign stat.pre_stop  = pre_stop;
   assign stat.walk_last = lag_valid_ff && ((lag_ff == end_ff) || hit);

   // Memory ports: push writes at the tail, removal shifts each later entry one place down.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot_of(head_ff, count_ff);
      wr_data = val_ff;
      if (cmd.finish_check && push_ok) begin
         wr_en = 1'b1;
      end else if (cmd.walk_step && lag_valid_ff && (op_ff == OP_REMOVE) && !is_first) begin
         wr_en   = 1'b1;
         wr_addr = slot_of(head_ff, lag_ff - CW'(1));
         wr_data = rd_raw;
      end
   end

   assign rd_addr = slot_of(head_ff, scan_ff);

   sfq_ram #(
      .WIDTH (ValueWidth),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // Pointer updates at the end of an operation.
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.finish_check && push_ok) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.finish_walk) begin
         if (op_ff == OP_POP) begin
            head_in  = slot_of(head_ff, CW'(1));
            count_in = count_ff - CW'(1);
         end else if (op_ff == OP_REMOVE) begin
            count_in = count_ff - CW'(1);
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         lag_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         if (cmd.walk_init) begin
            lag_valid_ff <= 1'b0;
         end else if (cmd.walk_step) begin
            lag_valid_ff <= 1'b1;
         end
      end
   end

   // Request capture, walk counters and running result.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_payload.operation;
         val_ff <= req_payload.value;
         pos_ff <= req_payload.position;
      end
      if (cmd.walk_init) begin
         scan_ff  <= start_off;
         start_ff <= start_off;
         end_ff   <= end_off;
      end else if (cmd.walk_step && !stat.walk_last) begin
         scan_ff <= scan_ff + CW'(1);
         lag_ff  <= scan_ff;
      end
      if (cmd.walk_step) begin
         acc_ff <= acc_in;
      end
   end

   // Response word.
   always_ff @(posedge clock) begin
      if (cmd.finish_check) begin
         rsp_ff.data           <= '0;
         rsp_ff.found_position <= '0;
         rsp_ff.status         <= pre_status;
         rsp_ff.length         <= PosWidth'(count_in);
      end else if (cmd.finish_walk) begin
         rsp_ff.data           <= (op_ff == OP_SEARCH) ? '0 : acc_in;
         rsp_ff.found_position <= hit ? PosWidth'(lag_ff + CW'(1)) : '0;
         rsp_ff.status         <= ((op_ff == OP_SEARCH) && !hit) ? ST_NOTFOUND : ST_OK;
         rsp_ff.length         <= PosWidth'(count_in);
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

/* src/searchable_fifo_queue.sv */
// Top level of the searchable FIFO queue: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// A request word is taken when start is high and busy is low; exactly one
// response word follows, shown for one cycle with rsp_valid, and the receiver
// cannot stall it. Push and every rejected operation answer from the check
// state, without a walk. Pop and peek walk a single entry. Search, maximum and
// removal read the entry store one entry per cycle through its single read
// port: search walks until a hit or the whole length, maximum the whole length,
// and removal the entries from the position to the tail, writing each later
// entry one place down as it goes. busy stays high until the response is
// registered; a new request may be given in the cycle its predecessor's response
// is shown. The data of an entry never written is never used.
module searchable_fifo_queue #(
   parameter int DEPTH = sfq_pkg::DefaultDepth
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   input  wire sfq_pkg::req_type  req_payload,
   output logic                   busy,
   output logic                   rsp_valid,
   output sfq_pkg::rsp_type       rsp_payload
);
   import sfq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   sfq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   sfq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* tb/tb_searchable_fifo_queue.sv */
// Self-checking testbench for the searchable FIFO queue with a built-in predictor.
`timescale 1ns / 1ps

module tb_searchable_fifo_queue;
   import sfq_pkg::*;

   localparam int QueueDepth = DefaultDepth;
   localparam int ReqBits    = $bits(req_type);
   localparam int RandWords  = 1200;
   localparam int TailCycles = 40;
   localparam int CycleLimit = 400000;

   // One pending request word, with the idle cycles to leave before it and
   // whether the sender must first wait for every outstanding response.
   typedef struct {
      req_type word;
      int      gap;
      bit      drain;
   } queued_word_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_payload = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_payload;

   queued_word_type pending_words[$];
   rsp_type         expected_rsp[$];
   rsp_type         oldest_rsp;

   int sent_count = 0;
   int rcvd_count = 0;
   int idle_left = 0;
   int error_count = 0;
   int cycle_count = 0;
   int gen_count = 0;

   // Predicted contents of the queue.
   logic signed [ValueWidth-1:0] shadow_entries[QueueDepth];
   int shadow_head = 0;
   int shadow_count = 0;

   searchable_fifo_queue uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_payload(req_payload),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Store slot of the entry at a given offset from the head.
   function automatic int slot_at(input int offset);
      return (shadow_head + offset) % QueueDepth;
   endfunction

   // Apply one request word to the shadow queue and return the response it must give.
   function automatic rsp_type predict_queue_op(input req_type word);
      rsp_type                      r;
      logic signed [ValueWidth-1:0] best;
      int                           i;
      int                           pos;
      r = '0;
      r.status = ST_OK;
      pos = int'(word.position);
      case (word.operation)
         OP_PUSH: begin
            if (shadow_count >= QueueDepth) begin
               r.status = ST_FULL;
            end else begin
               shadow_entries[slot_at(shadow_count)] = word.value;
               shadow_count++;
            end
         end
         OP_POP: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.data = shadow_entries[shadow_head];
               shadow_head = slot_at(1);
               shadow_count--;
            end
         end
         OP_PEEK: begin
            if (pos >= shadow_count) r.status = ST_RANGE;
            else r.data = shadow_entries[slot_at(pos)];
         end
         OP_SEARCH: begin
            r.status = ST_NOTFOUND;
            for (i = 0; i < shadow_count; i++) begin
               if (r.status != ST_OK && shadow_entries[slot_at(i)] == word.value) begin
                  r.found_position = 5'(i + 1);
                  r.status = ST_OK;
               end
            end
         end
         OP_MAX: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               best = shadow_entries[slot_at(0)];
               for (i = 1; i < shadow_count; i++) begin
                  if (shadow_entries[slot_at(i)] > best) best = shadow_entries[slot_at(i)];
               end
               r.data = best;
            end
         end
         OP_REMOVE: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else if (pos == 0 || pos > shadow_count) begin
               r.status = ST_RANGE;
            end else begin
               r.data = shadow_entries[slot_at(pos - 1)];
               for (i = pos - 1; i + 1 < shadow_count; i++) begin
                  shadow_entries[slot_at(i)] = shadow_entries[slot_at(i + 1)];
               end
               shadow_count--;
            end
         end
         default: r.status = ST_RANGE;
      endcase
      r.length = 5'(shadow_count);
      return r;
   endfunction

   // Queue one request word and keep track of the length it leaves behind.
   function automatic void add_word(input int op, input int value, input int pos,
                                    input int gap, input bit drain);
      queued_word_type q;
      q.word.operation = OpWidth'(op);
      q.word.value     = ValueWidth'(value);
      q.word.position  = PosWidth'(pos);
      q.gap            = gap;
      q.drain          = drain;
      pending_words.push_back(q);
      if (op == int'(OP_PUSH) && gen_count < QueueDepth) gen_count++;
      else if (op == int'(OP_POP) && gen_count > 0) gen_count--;
      else if (op == int'(OP_REMOVE) && pos >= 1 && pos <= gen_count) gen_count--;
   endfunction

   // Idle cycles before a word: none unless idling is set, else mostly none or short.
   function automatic int pick_gap(input bit idling);
      int r;
      r = $urandom_range(99);
      if (!idling || r < 65) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Values come often from a small pool so that searches hit and maxima tie.
   function automatic int pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 35) return $urandom_range(8) - 4;
      if (r < 45) begin
         case ($urandom_range(3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return -1;
            default: return 0;
         endcase
      end
      return $urandom;
   endfunction

   // Driver: presents pending words, predicts each one as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_left <= 0;
         shadow_head = 0;
         shadow_count = 0;
      end else begin
         if (start && !busy) begin
            expected_rsp.push_back(predict_queue_op(req_payload));
            sent_count <= sent_count + 1;
         end
         if (start && busy) begin
            // Word not taken yet; hold it.
         end else if (idle_left > 0) begin
            idle_left <= idle_left - 1;
            start <= 1'b0;
            req_payload <= ReqBits'({$urandom, $urandom});
         end else if (pending_words.size() == 0) begin
            start <= 1'b0;
            req_payload <= ReqBits'({$urandom, $urandom});
         end else if (pending_words[0].gap > 0) begin
            idle_left <= pending_words[0].gap - 1;
            pending_words[0].gap = 0;
            start <= 1'b0;
            req_payload <= ReqBits'({$urandom, $urandom});
         end else if (pending_words[0].drain && (start || rcvd_count != sent_count)) begin
            start <= 1'b0;
            req_payload <= ReqBits'({$urandom, $urandom});
         end else begin
            start <= 1'b1;
            req_payload <= pending_words[0].word;
            pending_words.delete(0);
         end
      end
   end

   // Monitor: checks each response word against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         rcvd_count <= rcvd_count + 1;
         if (expected_rsp.size() == 0) begin
            $error("response word with no request outstanding");
            error_count++;
         end else begin
            oldest_rsp = expected_rsp.pop_front();
            if (rsp_payload.data !== oldest_rsp.data) begin
               $error("data: expected %0d, got %0d", oldest_rsp.data, rsp_payload.data);
               error_count++;
            end
            if (rsp_payload.found_position !== oldest_rsp.found_position) begin
               $error("found_position: expected %0d, got %0d",
                      oldest_rsp.found_position, rsp_payload.found_position);
               error_count++;
            end
            if (rsp_payload.status !== oldest_rsp.status) begin
               $error("status: expected %0d, got %0d", oldest_rsp.status, rsp_payload.status);
               error_count++;
            end
            if (rsp_payload.length !== oldest_rsp.length) begin
               $error("length: expected %0d, got %0d", oldest_rsp.length, rsp_payload.length);
               error_count++;
            end
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int i;
      int r;
      int op;
      int pos;
      int phase_left;
      int push_weight;
      bit idling;
      int rand_words;

      // Errors on an empty queue.
      add_word(OP_POP, 0, 0, 0, 0);
      add_word(OP_MAX, 0, 0, 0, 0);
      add_word(OP_REMOVE, 0, 1, 0, 0);
      add_word(OP_PEEK, 0, 0, 0, 0);
      add_word(OP_SEARCH, 0, 0, 0, 0);
      // Fill with the extremes first, then a ramp.
      add_word(OP_PUSH, 32'h8000_0000, 31, 0, 0);
      add_word(OP_PUSH, 32'h7fff_ffff, 0, 0, 0);
      add_word(OP_PUSH, -1, 16, 0, 0);
      for (i = 3; i < QueueDepth; i++) add_word(OP_PUSH, i - 8, 0, pick_gap(1), 0);
      // Push into a full queue, after all earlier responses are in.
      add_word(OP_PUSH, 5, 0, 0, 1);
      add_word(OP_MAX, 0, 0, 0, 0);
      add_word(OP_SEARCH, 32'h7fff_ffff, 0, 0, 0);
      add_word(OP_SEARCH, 1234, 0, 0, 0);
      add_word(OP_PEEK, 0, 15, 0, 0);
      add_word(OP_PEEK, 0, 16, 0, 0);
      add_word(OP_PEEK, 0, 31, 0, 0);
      add_word(OP_REMOVE, 0, 0, 0, 0);
      add_word(OP_REMOVE, 0, 17, 0, 0);
      add_word(OP_REMOVE, 0, 16, 0, 0);
      add_word(OP_REMOVE, 0, 1, 0, 0);
      add_word(6, 0, 0, 0, 0);
      add_word(7, 32'h8000_0000, 31, 0, 0);
      add_word(OP_POP, 0, 0, 0, 0);

      // Random phases that lean toward filling, balance or draining.
      rand_words = 0;
      phase_left = 0;
      push_weight = 45;
      idling = 1'b0;
      while (rand_words < RandWords) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(120, 30);
            case ($urandom_range(2))
               0: push_weight = 75;
               1: push_weight = 45;
               default: push_weight = 15;
            endcase
            idling = ($urandom_range(3) != 0);
            add_word(OP_MAX, 0, 0, pick_gap(idling),
                     rand_words == 0 || $urandom_range(9) < 3);
            rand_words++;
         end
         r = $urandom_range(99);
         if (r < 2) op = $urandom_range(7, 6);
         else if (r < 2 + push_weight) op = OP_PUSH;
         else op = $urandom_range(5, 1);
         if ($urandom_range(99) < 15) pos = $urandom_range(31);
         else if (op == int'(OP_PEEK) || op == int'(OP_REMOVE)) pos = $urandom_range(gen_count);
         else pos = $urandom_range(31);
         add_word(op, pick_value(), pos, pick_gap(idling), 0);
         rand_words++;
         phase_left--;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last word to be taken and answered, then watch the tail.
      @(negedge clock);
      while (pending_words.size() != 0 || start || rcvd_count != sent_count) @(negedge clock);
      repeat (TailCycles) @(negedge clock);
      if (expected_rsp.size() != 0) begin
         $error("%0d responses never arrived", expected_rsp.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog on the whole run.
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

endmodule

/* filelist.f */
src/sfq_pkg.sv
src/sfq_ram.sv
src/sfq_ctrl.sv
src/sfq_datapath.sv
src/searchable_fifo_queue.sv
tb/tb_searchable_fifo_queue.sv
